@@ hw/rtl/cartridge_bank_mapper_with_scanline_irq_top_assert.svh @@
// Assertion macros shared by cbm_regs and cbm_outbuf.
// CBM_ASSERT takes a label, clock, active-low reset, property and message; CBM_ASSERT_ALWAYS takes no reset.
`ifndef CARTRIDGE_BANK_MAPPER_WITH_SCANLINE_IRQ_TOP_ASSERT_SVH
`define CARTRIDGE_BANK_MAPPER_WITH_SCANLINE_IRQ_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Checked property, off while reset is held
`define CBM_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked property, also during reset
`define CBM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define CBM_ASSERT(lbl, clk, rst_n, prop, msg)
`define CBM_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

@@ hw/rtl/cbm_pkg.sv @@
package cbm_pkg;

    // Item kinds
    typedef enum logic [1:0] {
        CMD_WRITE     = 2'd0,
        CMD_TICK      = 2'd1,
        CMD_PRG_XLATE = 2'd2,
        CMD_CHR_XLATE = 2'd3
    } cmd_t;

    // Configuration register indexes
    typedef enum logic [0:0] {
        CFG_PRG_MASK = 1'b0,
        CFG_CHR_MASK = 1'b1
    } cfg_idx_t;

    localparam int unsigned CFG_DATA_W  = 8;
    localparam int unsigned PRG_WINDOWS = 3;
    localparam int unsigned CHR_WINDOWS = 8;

    localparam logic [7:0] PRG_MASK_RESET = 8'd31;
    localparam logic [7:0] CHR_MASK_RESET = 8'd255;
    localparam logic [7:0] CNT_MAX        = 8'hFF;

    // CPU write decode addresses
    localparam logic [15:0] ADDR_PRG0   = 16'h8000;
    localparam logic [15:0] ADDR_PRG1_A = 16'h8008;
    localparam logic [15:0] ADDR_PRG1_B = 16'h8010;
    localparam logic [15:0] ADDR_PRG2   = 16'h9000;
    localparam logic [15:0] ADDR_CHR0   = 16'hA000;
    localparam logic [15:0] ADDR_CHR1_A = 16'hA008;
    localparam logic [15:0] ADDR_CHR1_B = 16'hA010;
    localparam logic [15:0] ADDR_CHR2   = 16'hB000;
    localparam logic [15:0] ADDR_CHR3_A = 16'hB008;
    localparam logic [15:0] ADDR_CHR3_B = 16'hB010;
    localparam logic [15:0] ADDR_CHR4   = 16'hC000;
    localparam logic [15:0] ADDR_CHR5_A = 16'hC008;
    localparam logic [15:0] ADDR_CHR5_B = 16'hC010;
    localparam logic [15:0] ADDR_CHR6   = 16'hD000;
    localparam logic [15:0] ADDR_CHR7_A = 16'hD008;
    localparam logic [15:0] ADDR_CHR7_B = 16'hD010;
    localparam logic [15:0] ADDR_MIRROR = 16'hE000;
    localparam logic [15:0] ADDR_LATCH_A = 16'hE008;
    localparam logic [15:0] ADDR_LATCH_B = 16'hE010;
    localparam logic [15:0] ADDR_CTRL   = 16'hF000;
    localparam logic [15:0] ADDR_ACK_A  = 16'hF008;
    localparam logic [15:0] ADDR_ACK_B  = 16'hF010;

    // Program window codes (address bits 14:13)
    typedef enum logic [1:0] {
        PWIN_0    = 2'd0,
        PWIN_1    = 2'd1,
        PWIN_2    = 2'd2,
        PWIN_LAST = 2'd3
    } prg_win_t;

    typedef struct packed {
        cmd_t        cmd;
        logic [15:0] address;
        logic [7:0]  write_data;
    } s_item_t;

    typedef struct packed {
        logic       irq_pulse;
        logic       mapped;
        logic [7:0] bank_number;
        logic [1:0] mirror_mode;
        logic [7:0] irq_count;
    } m_item_t;

endpackage

@@ hw/rtl/cbm_regs.sv @@
`include "cartridge_bank_mapper_with_scanline_irq_top_assert.svh"

module cbm_regs
    import cbm_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  cfg_idx_t              cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  in_fire,
    input  s_item_t               in_item,
    output m_item_t               res
);

    logic [7:0] prg_mask_reg;
    logic [7:0] chr_mask_reg;
    logic [7:0] prg_sel_reg  [PRG_WINDOWS];
    logic [7:0] prg_sel_next [PRG_WINDOWS];
    logic [7:0] chr_sel_reg  [CHR_WINDOWS];
    logic [7:0] chr_sel_next [CHR_WINDOWS];
    logic       prg_third_reg, prg_third_next;
    logic [1:0] mirror_reg, mirror_next;
    logic [7:0] irq_counter_reg, irq_counter_next;
    logic [7:0] irq_latch_reg, irq_latch_next;
    logic       irq_enable_reg, irq_enable_next;
    logic       irq_wait_reg, irq_wait_next;
    logic       pulse;
    logic [7:0] prg_raw;
    logic [7:0] bank;
    logic       mapped;
    prg_win_t   pwin;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prg_mask_reg <= PRG_MASK_RESET;
            chr_mask_reg <= CHR_MASK_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_PRG_MASK: prg_mask_reg <= cfg_wdata;
                CFG_CHR_MASK: chr_mask_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Write decode and scanline counter
    always_comb begin
        prg_sel_next     = prg_sel_reg;
        chr_sel_next     = chr_sel_reg;
        prg_third_next   = prg_third_reg;
        mirror_next      = mirror_reg;
        irq_counter_next = irq_counter_reg;
        irq_latch_next   = irq_latch_reg;
        irq_enable_next  = irq_enable_reg;
        irq_wait_next    = irq_wait_reg;
        pulse            = 1'b0;
        case (in_item.cmd)
            CMD_WRITE: begin
                case (in_item.address)
                    ADDR_PRG0: prg_sel_next[0] = in_item.write_data;
                    ADDR_PRG1_A, ADDR_PRG1_B: prg_sel_next[1] = in_item.write_data;
                    ADDR_PRG2: begin
                        prg_sel_next[2] = in_item.write_data;
                        prg_third_next  = 1'b1;
                    end
                    ADDR_CHR0: chr_sel_next[0] = in_item.write_data;
                    ADDR_CHR1_A, ADDR_CHR1_B: chr_sel_next[1] = in_item.write_data;
                    ADDR_CHR2: chr_sel_next[2] = in_item.write_data;
                    ADDR_CHR3_A, ADDR_CHR3_B: chr_sel_next[3] = in_item.write_data;
                    ADDR_CHR4: chr_sel_next[4] = in_item.write_data;
                    ADDR_CHR5_A, ADDR_CHR5_B: chr_sel_next[5] = in_item.write_data;
                    ADDR_CHR6: chr_sel_next[6] = in_item.write_data;
                    ADDR_CHR7_A, ADDR_CHR7_B: chr_sel_next[7] = in_item.write_data;
                    ADDR_MIRROR: mirror_next = in_item.write_data[1:0];
                    ADDR_LATCH_A, ADDR_LATCH_B: irq_latch_next = in_item.write_data;
                    ADDR_CTRL: begin
                        irq_wait_next   = in_item.write_data[0];
                        irq_enable_next = in_item.write_data[1];
                        if (in_item.write_data[1]) begin
                            irq_counter_next = irq_latch_reg;
                        end
                    end
                    ADDR_ACK_A, ADDR_ACK_B: irq_enable_next = irq_wait_reg;
                    default: ;
                endcase
            end
            CMD_TICK: begin
                if (irq_enable_reg) begin
                    if (irq_counter_reg == CNT_MAX) begin
                        irq_counter_next = irq_latch_reg;
                        pulse            = 1'b1;
                    end else begin
                        irq_counter_next = irq_counter_reg + 8'd1;
                    end
                end
            end
            default: ;
        endcase
    end

    // Program bank lookup; last window always shows the mask itself
    assign pwin = prg_win_t'(in_item.address[14:13]);

    always_comb begin
        case (pwin)
            PWIN_0:    prg_raw = prg_sel_reg[0];
            PWIN_1:    prg_raw = prg_sel_reg[1];
            PWIN_2:    prg_raw = prg_third_reg ? prg_sel_reg[2] : prg_mask_reg - 8'd1;
            PWIN_LAST: prg_raw = prg_mask_reg;
            default:   prg_raw = prg_mask_reg;
        endcase
    end

    // Translate result
    always_comb begin
        bank   = 8'd0;
        mapped = 1'b0;
        case (in_item.cmd)
            CMD_PRG_XLATE: begin
                if (in_item.address[15]) begin
                    bank   = prg_raw & prg_mask_reg;
                    mapped = 1'b1;
                end
            end
            CMD_CHR_XLATE: begin
                if (in_item.address[15:13] == 3'd0) begin
                    bank   = chr_sel_reg[in_item.address[12:10]] & chr_mask_reg;
                    mapped = 1'b1;
                end
            end
            default: ;
        endcase
    end

    assign res.irq_pulse   = pulse;
    assign res.mapped      = mapped;
    assign res.bank_number = bank;
    assign res.mirror_mode = mirror_next;
    assign res.irq_count   = irq_counter_next;

    // Mapper state, updated on each accepted transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prg_sel_reg[0]  <= 8'd0;
            prg_sel_reg[1]  <= 8'd1;
            prg_sel_reg[2]  <= 8'd0;
            for (int i = 0; i < CHR_WINDOWS; i++) begin
                chr_sel_reg[i] <= 8'(i);
            end
            prg_third_reg   <= 1'b0;
            mirror_reg      <= 2'd0;
            irq_counter_reg <= 8'd0;
            irq_latch_reg   <= 8'd0;
            irq_enable_reg  <= 1'b0;
            irq_wait_reg    <= 1'b0;
        end else if (in_fire) begin
            prg_sel_reg     <= prg_sel_next;
            chr_sel_reg     <= chr_sel_next;
            prg_third_reg   <= prg_third_next;
            mirror_reg      <= mirror_next;
            irq_counter_reg <= irq_counter_next;
            irq_latch_reg   <= irq_latch_next;
            irq_enable_reg  <= irq_enable_next;
            irq_wait_reg    <= irq_wait_next;
        end
    end

    `CBM_ASSERT(a_tick_off_holds, aclk, aresetn, in_fire && in_item.cmd == CMD_TICK && !irq_enable_reg |=> $stable(irq_counter_reg), "counter moved while disabled")
    `CBM_ASSERT(a_pulse_reload, aclk, aresetn, in_fire && res.irq_pulse |=> irq_counter_reg == $past(irq_latch_reg), "overflow did not reload from latch")
    `CBM_ASSERT(a_pulse_on_tick, aclk, aresetn, res.irq_pulse |-> in_item.cmd == CMD_TICK, "pulse on a non-tick item")

endmodule

@@ hw/rtl/cbm_outbuf.sv @@
`include "cartridge_bank_mapper_with_scanline_irq_top_assert.svh"

module cbm_outbuf
    import cbm_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    in_valid,
    output logic    in_ready,
    input  m_item_t in_data,
    output logic    m_valid,
    input  logic    m_ready,
    output m_item_t m_data
);

    logic    out_valid_reg, out_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    m_item_t out_data_reg, out_data_next;
    m_item_t skid_data_reg, skid_data_next;
    logic    in_fire;

    // Input side stalls only when the skid entry is full
    assign in_ready = !skid_valid_reg;
    assign in_fire  = in_valid && in_ready;

    // Output register with one skid entry behind it
    always_comb begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || m_ready) begin
            if (skid_valid_reg) begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end else begin
                out_valid_next = in_fire;
                out_data_next  = in_data;
            end
        end else if (in_fire) begin
            skid_valid_next = 1'b1;
            skid_data_next  = in_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Payload, no reset needed
    always_ff @(posedge aclk) begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    `CBM_ASSERT(a_skid_behind_out, aclk, aresetn, !skid_valid_reg || out_valid_reg, "skid full with output empty")
    `CBM_ASSERT(a_stall_fills_skid, aclk, aresetn, out_valid_reg && !m_ready && in_fire |=> skid_valid_reg, "stalled transfer lost")
    `CBM_ASSERT(a_skid_drains, aclk, aresetn, skid_valid_reg && m_ready |=> out_valid_reg && !skid_valid_reg, "skid entry did not move up")

endmodule

@@ hw/rtl/cartridge_bank_mapper_with_scanline_irq_top.sv @@
// Cartridge bank mapper with a scanline interrupt counter. Every transfer on
// the s_ channel (CPU write, scanline tick, program or pattern translate)
// yields exactly one result on the m_ channel, at the earliest in the cycle
// after it is taken; the block takes one transfer per clock while s_ready is
// high, set by the single decode and 8-bit increment stage in front of the
// result register. A two-entry buffer (result register plus skid entry) keeps
// s_ready high until two results are waiting. The user must write bank masks
// through the cfg_ port only while no transfer is in flight; the block does not enforce it.
module cartridge_bank_mapper_with_scanline_irq_top
    import cbm_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  cfg_idx_t              cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  s_item_t               s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output m_item_t               m_data
);

    logic    s_fire;
    m_item_t res;

    assign s_fire = s_valid && s_ready;

    // Decode, state and translate
    cbm_regs u_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_fire   (s_fire),
        .in_item   (s_data),
        .res       (res)
    );

    // Result register and skid
    cbm_outbuf u_outbuf (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_valid),
        .in_ready (s_ready),
        .in_data  (res),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule

@@ test/tb.sv @@
`timescale 1ns / 1ps

module tb;
    import cbm_pkg::*;

    localparam logic [15:0] CHR_SPAN = 16'h2000;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_we;
    cfg_idx_t              cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_valid;
    logic                  s_ready;
    s_item_t               s_data;
    logic                  m_valid;
    logic                  m_ready;
    m_item_t               m_data;

    cartridge_bank_mapper_with_scanline_irq_top u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    // Mapper state as the testbench tracks it
    logic [7:0] prg_pick [0:2];
    logic       prg_pick2_done;
    logic [7:0] chr_pick [0:7];
    logic [1:0] mirror_now;
    logic [7:0] irq_cnt;
    logic [7:0] irq_reload;
    logic       irq_on;
    logic       irq_armed;
    logic [7:0] prg_mask;
    logic [7:0] chr_mask;

    m_item_t mapper_results_due [$];
    int      error_count = 0;
    bit      idling_allowed = 1'b1;
    int      stall_cycles = 0;

    logic [15:0] decode_addrs [0:21] = '{
        ADDR_PRG0, ADDR_PRG1_A, ADDR_PRG1_B, ADDR_PRG2,
        ADDR_CHR0, ADDR_CHR1_A, ADDR_CHR1_B, ADDR_CHR2,
        ADDR_CHR3_A, ADDR_CHR3_B, ADDR_CHR4, ADDR_CHR5_A,
        ADDR_CHR5_B, ADDR_CHR6, ADDR_CHR7_A, ADDR_CHR7_B,
        ADDR_MIRROR, ADDR_LATCH_A, ADDR_LATCH_B, ADDR_CTRL,
        ADDR_ACK_A, ADDR_ACK_B
    };

    // Clock
    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Run limit
    initial begin
        #2_000_000;
        $display("status: fail");
        $finish;
    end

    // Advance the tracked mapper state by one bus item, return its result
    function automatic m_item_t apply_bus_item(input s_item_t item);
        m_item_t    res;
        logic [7:0] raw;
        logic [7:0] val;
        res = '0;
        val = item.write_data;
        case (item.cmd)
            CMD_WRITE: begin
                case (item.address)
                    ADDR_PRG0:                prg_pick[0] = val;
                    ADDR_PRG1_A, ADDR_PRG1_B: prg_pick[1] = val;
                    ADDR_PRG2: begin
                        prg_pick[2] = val;
                        prg_pick2_done = 1'b1;
                    end
                    ADDR_CHR0:                chr_pick[0] = val;
                    ADDR_CHR1_A, ADDR_CHR1_B: chr_pick[1] = val;
                    ADDR_CHR2:                chr_pick[2] = val;
                    ADDR_CHR3_A, ADDR_CHR3_B: chr_pick[3] = val;
                    ADDR_CHR4:                chr_pick[4] = val;
                    ADDR_CHR5_A, ADDR_CHR5_B: chr_pick[5] = val;
                    ADDR_CHR6:                chr_pick[6] = val;
                    ADDR_CHR7_A, ADDR_CHR7_B: chr_pick[7] = val;
                    ADDR_MIRROR:              mirror_now = val[1:0];
                    ADDR_LATCH_A, ADDR_LATCH_B: irq_reload = val;
                    ADDR_CTRL: begin
                        irq_armed = val[0];
                        irq_on    = val[1];
                        if (val[1]) irq_cnt = irq_reload;
                    end
                    ADDR_ACK_A, ADDR_ACK_B:   irq_on = irq_armed;
                    default: ;
                endcase
            end
            CMD_TICK: begin
                if (irq_on) begin
                    if (irq_cnt == CNT_MAX) begin
                        irq_cnt = irq_reload;
                        res.irq_pulse = 1'b1;
                    end else begin
                        irq_cnt = irq_cnt + 8'd1;
                    end
                end
            end
            CMD_PRG_XLATE: begin
                if (item.address[15]) begin
                    // last window is fixed; third shows mask-1 until its select is written
                    if (prg_win_t'(item.address[14:13]) == PWIN_LAST) begin
                        raw = prg_mask;
                    end else if (prg_win_t'(item.address[14:13]) == PWIN_2 && !prg_pick2_done) begin
                        raw = prg_mask - 8'd1;
                    end else begin
                        raw = prg_pick[item.address[14:13]];
                    end
                    res.bank_number = raw & prg_mask;
                    res.mapped      = 1'b1;
                end
            end
            CMD_CHR_XLATE: begin
                if (item.address < CHR_SPAN) begin
                    res.bank_number = chr_pick[item.address[12:10]] & chr_mask;
                    res.mapped      = 1'b1;
                end
            end
            default: ;
        endcase
        res.mirror_mode = mirror_now;
        res.irq_count   = irq_cnt;
        return res;
    endfunction

    // Mostly decoded writes, ticks and in-window translates; the rest is noise
    function automatic s_item_t random_bus_item();
        s_item_t     item;
        int unsigned pick;
        pick            = $urandom_range(0, 99);
        item.address    = 16'($urandom_range(0, 65535));
        item.write_data = 8'($urandom_range(0, 255));
        if (pick < 35) begin
            item.cmd = CMD_WRITE;
            if ($urandom_range(0, 4) != 0) item.address = decode_addrs[5'($urandom_range(0, 21))];
            if ((item.address == ADDR_LATCH_A || item.address == ADDR_LATCH_B)
                    && $urandom_range(0, 1) == 1) begin
                // high latch values make overflows frequent
                item.write_data = 8'($urandom_range(240, 255));
            end else if ($urandom_range(0, 7) == 0) begin
                item.write_data = ($urandom_range(0, 1) == 1) ? 8'hFF : 8'h00;
            end
        end else if (pick < 65) begin
            item.cmd = CMD_TICK;
        end else if (pick < 85) begin
            item.cmd = CMD_PRG_XLATE;
            if ($urandom_range(0, 4) != 0) item.address[15] = 1'b1;
        end else begin
            item.cmd = CMD_CHR_XLATE;
            if ($urandom_range(0, 4) != 0) item.address[15:13] = 3'b000;
        end
        return item;
    endfunction

    // Power of two minus one mostly, any byte now and then
    function automatic logic [7:0] random_mask();
        if ($urandom_range(0, 3) == 0) return 8'($urandom_range(0, 255));
        return 8'((9'd1 << $urandom_range(0, 8)) - 9'd1);
    endfunction

    // One input transfer; valid stays up for a following item
    task automatic send_item(input cmd_t cmd, input logic [15:0] addr, input logic [7:0] wdata);
        s_item_t item;
        item.cmd        = cmd;
        item.address    = addr;
        item.write_data = wdata;
        if (idling_allowed && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        mapper_results_due.push_back(apply_bus_item(item));
    endtask

    task automatic send_random(input int count);
        s_item_t item;
        repeat (count) begin
            item = random_bus_item();
            send_item(item.cmd, item.address, item.write_data);
        end
    endtask

    // Stop sending and wait for every expected result
    task automatic drain_results();
        s_valid <= 1'b0;
        while (mapper_results_due.size() != 0) @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    // Both mask registers, written while the block is idle
    task automatic write_masks(input logic [7:0] prg, input logic [7:0] chr);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_PRG_MASK;
        cfg_wdata <= prg;
        @(posedge aclk);
        cfg_index <= CFG_CHR_MASK;
        cfg_wdata <= chr;
        @(posedge aclk);
        cfg_we <= 1'b0;
        prg_mask = prg;
        chr_mask = chr;
    endtask

    task automatic report_mismatch(input string what, input m_item_t got, input m_item_t want);
        error_count++;
        if (error_count <= 100)
            $display("mismatch at %0t:%s got %0d/%0d/%0d/%0d/%0d want %0d/%0d/%0d/%0d/%0d",
                     $time, what, got.irq_pulse, got.mapped, got.bank_number,
                     got.mirror_mode, got.irq_count, want.irq_pulse, want.mapped,
                     want.bank_number, want.mirror_mode, want.irq_count);
    endtask

    // Reset mapping: mapped range edges, each program window, unwritten third window, disabled tick
    task automatic test_reset_mapping();
        send_item(CMD_PRG_XLATE, 16'h0000, 8'h00);
        send_item(CMD_PRG_XLATE, 16'h7FFF, 8'hFF);
        send_item(CMD_PRG_XLATE, 16'h8000, 8'h00);
        send_item(CMD_PRG_XLATE, 16'hA000, 8'h00);
        send_item(CMD_PRG_XLATE, 16'hC000, 8'h00);
        send_item(CMD_PRG_XLATE, 16'hFFFF, 8'h00);
        send_item(CMD_CHR_XLATE, 16'h0000, 8'h00);
        send_item(CMD_CHR_XLATE, 16'h1FFF, 8'h00);
        send_item(CMD_CHR_XLATE, 16'h2000, 8'h00);
        send_item(CMD_CHR_XLATE, 16'hFFFF, 8'h00);
        send_item(CMD_TICK, 16'h0000, 8'h00);
    endtask

    // Counter overflow, reload, acknowledge and disabled ticks
    task automatic test_irq_reload();
        send_item(CMD_WRITE, ADDR_LATCH_A, 8'hFE);
        send_item(CMD_WRITE, ADDR_CTRL, 8'h03);
        send_item(CMD_TICK, 16'hFFFF, 8'hFF);
        send_item(CMD_TICK, 16'h0000, 8'h00);
        send_item(CMD_WRITE, ADDR_ACK_B, 8'h00);
        send_item(CMD_WRITE, ADDR_CTRL, 8'h01);
        send_item(CMD_TICK, 16'h0000, 8'h00);
        send_item(CMD_WRITE, ADDR_ACK_A, 8'h00);
        send_item(CMD_TICK, 16'h0000, 8'h00);
    endtask

    // Bank and mirror writes, plus a near-miss address that must be ignored
    task automatic test_bank_writes();
        send_item(CMD_WRITE, ADDR_PRG2, 8'hFF);
        send_item(CMD_PRG_XLATE, 16'hDFFF, 8'h00);
        send_item(CMD_WRITE, ADDR_MIRROR, 8'hFF);
        send_item(CMD_WRITE, 16'h8001, 8'h55);
        send_item(CMD_WRITE, ADDR_CHR1_B, 8'h00);
        send_item(CMD_CHR_XLATE, 16'h0400, 8'h00);
    endtask

    // Zero, smallest and largest masks
    task automatic test_mask_extremes();
        write_masks(8'd0, 8'd0);
        send_random(40);
        write_masks(8'd1, 8'd1);
        send_random(40);
        write_masks(8'd255, 8'd255);
        send_random(40);
    endtask

    // Random traffic over several mask settings, idling on or off per phase
    task automatic test_random_traffic();
        repeat (8) begin
            write_masks(random_mask(), random_mask());
            idling_allowed = ($urandom_range(0, 3) != 0);
            send_random(140);
        end
    endtask

    // Back-to-back transfers with no idling on either side
    task automatic test_quiet_tail();
        write_masks(PRG_MASK_RESET, CHR_MASK_RESET);
        idling_allowed = 1'b0;
        send_random(100);
    endtask

    // Result side stalls in random bursts
    always @(posedge aclk) begin
        if (stall_cycles > 0) begin
            stall_cycles = stall_cycles - 1;
            m_ready <= 1'b0;
        end else if (idling_allowed && $urandom_range(0, 6) == 0) begin
            stall_cycles = $urandom_range(1, 15) - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Compare each result transfer against the oldest expectation
    always @(posedge aclk) begin
        m_item_t want;
        string   bad;
        if (aresetn && m_valid && m_ready) begin
            if (mapper_results_due.size() == 0) begin
                report_mismatch(" result with none expected", m_data, '0);
            end else begin
                want = mapper_results_due.pop_front();
                bad  = "";
                if (m_data.irq_pulse != want.irq_pulse)     bad = {bad, " irq_pulse"};
                if (m_data.mapped != want.mapped)           bad = {bad, " mapped"};
                if (m_data.bank_number != want.bank_number) bad = {bad, " bank_number"};
                if (m_data.mirror_mode != want.mirror_mode) bad = {bad, " mirror_mode"};
                if (m_data.irq_count != want.irq_count)     bad = {bad, " irq_count"};
                if (bad != "") report_mismatch(bad, m_data, want);
            end
        end
    end

    initial begin
        aresetn   = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = CFG_PRG_MASK;
        cfg_wdata = '0;
        s_valid   = 1'b0;
        s_data    = '0;
        m_ready   = 1'b0;

        // tracked state at reset
        prg_pick[0]    = 8'd0;
        prg_pick[1]    = 8'd1;
        prg_pick[2]    = 8'd0;
        prg_pick2_done = 1'b0;
        for (int i = 0; i < CHR_WINDOWS; i++) chr_pick[i] = 8'(i);
        mirror_now = 2'd0;
        irq_cnt    = 8'd0;
        irq_reload = 8'd0;
        irq_on     = 1'b0;
        irq_armed  = 1'b0;
        prg_mask   = PRG_MASK_RESET;
        chr_mask   = CHR_MASK_RESET;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        test_reset_mapping();
        test_irq_reload();
        test_bank_writes();
        test_mask_extremes();
        test_random_traffic();
        test_quiet_tail();

        drain_results();
        repeat (4) @(posedge aclk);
        if (error_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/cbm_pkg.sv
hw/rtl/cbm_regs.sv
hw/rtl/cbm_outbuf.sv
hw/rtl/cartridge_bank_mapper_with_scanline_irq_top.sv
test/tb.sv
